>>> src/gsp_pkg.sv
package gsp_pkg;

    localparam int CordicSteps = 28;
    localparam int AngW = 40;   // Q.32 angle with headroom
    localparam int TrigW = 34;  // Q2.30 with headroom for CORDIC growth

    localparam logic signed [AngW-1:0] PiQ32 = 40'sd13493037705;
    localparam logic signed [AngW-1:0] HalfPiQ32 = 40'sd6746518852;
    localparam logic signed [AngW-1:0] TwoPiQ32 = 40'sd26986075409;
    localparam logic signed [TrigW-1:0] GainQ30 = 34'sd652032874;
    localparam logic signed [TrigW-1:0] TinyQ30 = 34'sd1074;

    localparam logic signed [47:0] OutMax = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] OutMin = 48'sh8000_0000_0000;

    localparam int QuoW = 60;   // quotient bits tracked before saturation

    typedef enum logic [1:0] {
        ST_NORMAL   = 2'd0,
        ST_CLAMP_POS = 2'd1,
        ST_CLAMP_NEG = 2'd2,
        ST_BEHIND   = 2'd3
    } axis_status_t;

    localparam logic CFG_AZ = 1'b0;
    localparam logic CFG_EL = 1'b1;

    function automatic logic signed [AngW-1:0] atan_entry(input int i);
        logic signed [AngW-1:0] r;
        r = '0;
        case (i)
            0: r = 40'sd3373259426;
            1: r = 40'sd1991351318;
            2: r = 40'sd1052175346;
            3: r = 40'sd534100635;
            4: r = 40'sd268086748;
            5: r = 40'sd134174063;
            6: r = 40'sd67103403;
            7: r = 40'sd33553749;
            8: r = 40'sd16777131;
            9: r = 40'sd8388597;
            10: r = 40'sd4194303;
            default:
            begin
                if (i <= 32)
                    r = 40'sd1 <<< (32 - i);
            end
        endcase
        return r;
    endfunction

    function automatic logic signed [TrigW-1:0] mul30(input logic signed [TrigW-1:0] a,
                                                      input logic signed [TrigW-1:0] b);
        logic signed [2*TrigW-1:0] p;
        p = a * b;
        return p[TrigW+29:30];
    endfunction

endpackage

>>> src/gsp_sincos.sv
module gsp_sincos (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic signed [gsp_pkg::AngW-1:0]    angle,
    output logic signed [gsp_pkg::TrigW-1:0]   sin_out,
    output logic signed [gsp_pkg::TrigW-1:0]   cos_out
);
    import gsp_pkg::*;

    logic signed [AngW-1:0] a_reg [CordicSteps+1];
    logic signed [TrigW-1:0] x_reg [CordicSteps+1];
    logic signed [TrigW-1:0] y_reg [CordicSteps+1];
    logic neg_reg [CordicSteps+1];

    logic signed [AngW-1:0] red1;
    logic signed [AngW-1:0] red_next;
    logic neg_next;

    // A difference of two angles reaches about five times pi, so up to three
    // whole turns may have to be removed to land within +-pi.
    always_comb
    begin
        red1 = angle;
        if (angle > PiQ32 + TwoPiQ32 + TwoPiQ32)
            red1 = angle - TwoPiQ32 - TwoPiQ32 - TwoPiQ32;
        else if (angle > PiQ32 + TwoPiQ32)
            red1 = angle - TwoPiQ32 - TwoPiQ32;
        else if (angle > PiQ32)
            red1 = angle - TwoPiQ32;
        else if (angle < -PiQ32 - TwoPiQ32 - TwoPiQ32)
            red1 = angle + TwoPiQ32 + TwoPiQ32 + TwoPiQ32;
        else if (angle < -PiQ32 - TwoPiQ32)
            red1 = angle + TwoPiQ32 + TwoPiQ32;
        else if (angle < -PiQ32)
            red1 = angle + TwoPiQ32;
        red_next = red1;
        neg_next = 1'b0;
        if (red1 > HalfPiQ32)
        begin
            red_next = red1 - PiQ32;
            neg_next = 1'b1;
        end
        else if (red1 < -HalfPiQ32)
        begin
            red_next = red1 + PiQ32;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg[0] <= red_next;
        x_reg[0] <= GainQ30;
        y_reg[0] <= '0;
        neg_reg[0] <= neg_next;
    end

    for (genvar i = 0; i < CordicSteps; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            neg_reg[i+1] <= neg_reg[i];
            if (a_reg[i] >= 0)
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                a_reg[i+1] <= a_reg[i] - atan_entry(i);
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                a_reg[i+1] <= a_reg[i] + atan_entry(i);
            end
        end
    end

    assign sin_out = neg_reg[CordicSteps] ? -y_reg[CordicSteps] : y_reg[CordicSteps];
    assign cos_out = neg_reg[CordicSteps] ? -x_reg[CordicSteps] : x_reg[CordicSteps];

    logic unused_rst;
    assign unused_rst = rst_n;
endmodule

>>> src/gsp_divider.sv
module gsp_divider (
    input  logic                              clk,
    input  logic signed [gsp_pkg::TrigW-1:0]  num,
    input  logic signed [gsp_pkg::TrigW-1:0]  den,
    output logic signed [47:0]                quo
);
    import gsp_pkg::*;

    localparam int DW = TrigW + 24;

    // Restoring division on magnitudes, one quotient bit per stage.
    logic [DW-1:0]  n_reg [QuoW+1];
    logic [TrigW:0] d_reg [QuoW+1];
    logic [DW:0]    r_reg [QuoW+1];
    logic [QuoW-1:0] q_reg [QuoW+1];
    logic            s_reg [QuoW+1];

    logic signed [DW-1:0] nw;
    logic signed [TrigW:0] dw;
    always_comb
    begin
        nw = DW'(num) <<< 24;
        dw = (TrigW+1)'(den);
    end

    always_ff @(posedge clk)
    begin
        n_reg[0] <= nw[DW-1] ? DW'(-nw) : DW'(nw);
        d_reg[0] <= dw[TrigW] ? (TrigW+1)'(-dw) : (TrigW+1)'(dw);
        r_reg[0] <= '0;
        q_reg[0] <= '0;
        s_reg[0] <= nw[DW-1] ^ dw[TrigW];
    end

    for (genvar i = 0; i < QuoW; i++)
    begin : g_div
        logic [DW:0] trial;
        logic [DW:0] sub;
        always_comb
        begin
            if (QuoW - 1 - i < DW)
                trial = {r_reg[i][DW-1:0], n_reg[i][(QuoW-1-i) % DW]};
            else
                trial = {r_reg[i][DW-1:0], 1'b0};
            sub = trial - (DW+1)'(d_reg[i]);
        end
        always_ff @(posedge clk)
        begin
            n_reg[i+1] <= n_reg[i];
            d_reg[i+1] <= d_reg[i];
            s_reg[i+1] <= s_reg[i];
            if (!sub[DW])
            begin
                r_reg[i+1] <= sub;
                q_reg[i+1] <= {q_reg[i][QuoW-2:0], 1'b1};
            end
            else
            begin
                r_reg[i+1] <= trial;
                q_reg[i+1] <= {q_reg[i][QuoW-2:0], 1'b0};
            end
        end
    end

    logic [QuoW-1:0] mag;
    logic big;
    always_comb
    begin
        mag = q_reg[QuoW];
        big = |mag[QuoW-1:47];
        if (s_reg[QuoW])
            quo = (big && !(mag == (QuoW'(1) << 47))) || mag > (QuoW'(1) << 47)
                ? OutMin : -$signed(mag[47:0]);
        else
            quo = big ? OutMax : $signed(mag[47:0]);
    end
endmodule

>>> src/gnomonic_sphere_to_plane.sv
// Gnomonic projection of a direction onto the tangent plane.
// Configuration: write cfg_index 0 (tangent azimuth) or 1 (tangent
// elevation) with cfg_data while cfg_valid is high; cfg_ready is always
// high. Both registers reset to zero. Write only while the pipeline is empty.
// Items: a word enters when start is high and busy low; busy is never
// raised, so one word may enter on every cycle.
// Results: plane_x, plane_y and axis_status appear for one cycle with
// done high, after one reduction stage, 28 CORDIC steps, three product
// and sum stages, one divider entry stage and 60 quotient stages.
// The receiver cannot stall; every word produces exactly one result.
// Reset clears the valid bits of the pipeline, so no stale result appears.
module gnomonic_sphere_to_plane (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [31:0] point_azimuth,
    input  logic signed [31:0] point_elevation,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output logic        done,
    output logic signed [47:0] plane_x,
    output logic signed [47:0] plane_y,
    output logic [1:0]  axis_status
);
    import gsp_pkg::*;

    localparam int Lat = CordicSteps + 1 + 3 + QuoW + 1;

    logic signed [31:0] taz_reg, tel_reg;
    logic [Lat-1:0] vld_reg;

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taz_reg <= '0;
            tel_reg <= '0;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_index == CFG_AZ)
                taz_reg <= cfg_data;
            if (cfg_valid && cfg_index == CFG_EL)
                tel_reg <= cfg_data;
            vld_reg <= {vld_reg[Lat-2:0], start};
        end
    end

    logic signed [AngW-1:0] ang_el, ang_el0, ang_d;
    assign ang_el = AngW'(point_elevation) <<< 4;
    assign ang_el0 = AngW'(tel_reg) <<< 4;
    assign ang_d = (AngW'(point_azimuth) - AngW'(taz_reg)) <<< 4;

    logic signed [TrigW-1:0] sd, cd, sz, cz, sr, cr;
    gsp_sincos u_el  (.clk, .rst_n, .angle(ang_el),  .sin_out(sd), .cos_out(cd));
    gsp_sincos u_el0 (.clk, .rst_n, .angle(ang_el0), .sin_out(sz), .cos_out(cz));
    gsp_sincos u_d   (.clk, .rst_n, .angle(ang_d),   .sin_out(sr), .cos_out(cr));

    // Stage 1 products, stage 2 products by cos(diff), stage 3 sums and clamp.
    logic signed [TrigW-1:0] p_sdsz_reg, p_cdcz_reg, p_cdsz_reg, p_sdcz_reg, nx1_reg, cr1_reg;
    logic signed [TrigW-1:0] p_sdsz2_reg, p_sdcz2_reg, q_den_reg, q_ny_reg, nx2_reg;
    logic signed [TrigW-1:0] den_reg, ny_reg, nx3_reg;
    logic [1:0] st_reg;
    logic [1:0] st_dly_reg [QuoW+1];

    always_ff @(posedge clk)
    begin
        p_sdsz_reg <= mul30(sd, sz);
        p_cdcz_reg <= mul30(cd, cz);
        p_cdsz_reg <= mul30(cd, sz);
        p_sdcz_reg <= mul30(sd, cz);
        nx1_reg <= mul30(cd, sr);
        cr1_reg <= cr;
        p_sdsz2_reg <= p_sdsz_reg;
        p_sdcz2_reg <= p_sdcz_reg;
        q_den_reg <= mul30(p_cdcz_reg, cr1_reg);
        q_ny_reg <= mul30(p_cdsz_reg, cr1_reg);
        nx2_reg <= nx1_reg;
        ny_reg <= p_sdcz2_reg - q_ny_reg;
        nx3_reg <= nx2_reg;
    end

    logic signed [TrigW-1:0] den_sum;
    assign den_sum = p_sdsz2_reg + q_den_reg;

    always_ff @(posedge clk)
    begin
        if (den_sum > TinyQ30)
        begin
            den_reg <= den_sum;
            st_reg <= ST_NORMAL;
        end
        else if (den_sum >= 0)
        begin
            den_reg <= TinyQ30;
            st_reg <= ST_CLAMP_POS;
        end
        else if (den_sum > -TinyQ30)
        begin
            den_reg <= -TinyQ30;
            st_reg <= ST_CLAMP_NEG;
        end
        else
        begin
            den_reg <= den_sum;
            st_reg <= ST_BEHIND;
        end
    end

    always_ff @(posedge clk)
    begin
        st_dly_reg[0] <= st_reg;
        for (int i = 0; i < QuoW; i++)
            st_dly_reg[i+1] <= st_dly_reg[i];
    end

    gsp_divider u_divx (.clk, .num(nx3_reg), .den(den_reg), .quo(plane_x));
    gsp_divider u_divy (.clk, .num(ny_reg),  .den(den_reg), .quo(plane_y));

    assign axis_status = st_dly_reg[QuoW];
    assign done = vld_reg[Lat-1];

    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, Lat))
        else $error("result without a word");
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_index == CFG_AZ) |=> taz_reg == $past(cfg_data))
        else $error("azimuth write lost");
endmodule
